// File: hdl/nne_pkg.sv
// Package for the NAND netlist evaluator.
// Holds default sizes, field widths, request codes and controller states.
// No dependencies.
package nne_pkg;

	localparam int DATA_BITS_DEF        = 8;
	localparam int GATE_COUNT_DEF       = 256;
	localparam int DIRECT_OUTPUTS_DEF   = 8;
	localparam int FEEDBACK_OUTPUTS_DEF = 8;

	localparam int REQ_W    = 2;
	localparam int CH_IDX_W = 9;
	localparam int SRC_W    = 2 * CH_IDX_W;
	localparam int OPER_W   = 8;
	localparam int RES_W    = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_GATE_WR = 2'd0,
		REQ_MAP_WR  = 2'd1,
		REQ_EVAL    = 2'd2,
		REQ_EVAL_FB = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_GW_WR,
		ST_EVAL,
		ST_OUT_RD,
		ST_OUT_CH,
		ST_OUT_COL,
		ST_RESP
	} state_t;

endpackage

// File: hdl/nne_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for gate sources, output map and channel values. No dependencies.
module nne_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/nand_netlist_evaluator_unit.sv
// NAND netlist evaluator top level; needs nne_pkg and nne_ram. A gate-source write reads the
// old entry, then writes it; an output-map write is done in decode. Evaluation does one gate-table
// read per cycle through a three-stage read/NAND/write loop, then for each output slot a map
// read, a channel read and a collect step.
// One word in flight; the next can be taken in the cycle the result word rises, later on a stall.
// Reset: a clearing pass zeroes every gate table and map entry first.
module nand_netlist_evaluator_unit import nne_pkg::*; #(
	parameter int DATA_BITS        = DATA_BITS_DEF,
	parameter int GATE_COUNT       = GATE_COUNT_DEF,
	parameter int DIRECT_OUTPUTS   = DIRECT_OUTPUTS_DEF,
	parameter int FEEDBACK_OUTPUTS = FEEDBACK_OUTPUTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [CH_IDX_W-1:0] target,
	input  logic [CH_IDX_W-1:0] first_source,
	input  logic [CH_IDX_W-1:0] second_source,
	input  logic                set_first,
	input  logic                set_second,
	input  logic [OPER_W-1:0]   operand_a,
	input  logic [OPER_W-1:0]   operand_b,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [RES_W-1:0]    result,
	output logic                error
);

	localparam int NIN    = 2 * DATA_BITS;
	localparam int NCH    = NIN + GATE_COUNT;
	localparam int NSLOTS = DIRECT_OUTPUTS + FEEDBACK_OUTPUTS;
	localparam int CW     = ($clog2(NCH + 1) > CH_IDX_W) ? $clog2(NCH + 1) : CH_IDX_W;
	localparam int GW     = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
	localparam int GCW    = $clog2(GATE_COUNT + 1);
	localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int NIW    = $clog2(NIN);
	localparam int FBN    = (FEEDBACK_OUTPUTS > 0) ? FEEDBACK_OUTPUTS : 1;
	localparam int FW     = (FBN > 1) ? $clog2(FBN) : 1;
	localparam int CLR_N  = (GATE_COUNT > NSLOTS) ? GATE_COUNT : NSLOTS;
	localparam int CLW    = $clog2(CLR_N + 1);

	typedef struct packed {
		logic          use_ram;
		logic          val;
		logic [GW-1:0] addr;
	} src_cls_t;

	function automatic src_cls_t classify(
		input logic [CH_IDX_W-1:0] src,
		input logic [CW-1:0]       cur,
		input logic [NIN-1:0]      ich,
		input logic                fwd_v,
		input logic [GW-1:0]       fwd_g,
		input logic                fwd_val
	);
		src_cls_t  c;
		logic [CW-1:0] w;
		logic [CW-1:0] off;
		w         = CW'(src);
		off       = w - CW'(NIN);
		c.use_ram = 1'b0;
		c.val     = 1'b0;
		c.addr    = off[GW-1:0];
		if (w < CW'(NIN)) begin
			c.val = ich[src[NIW-1:0]];
		end else if (w < cur) begin
			if (fwd_v && (off[GW-1:0] == fwd_g)) begin
				c.val = fwd_val;
			end else begin
				c.use_ram = 1'b1;
			end
		end
		return c;
	endfunction

	state_t state_q, state_d;

	req_type_t           req_q;
	logic [CH_IDX_W-1:0] tgt_q, s1_q, s2_q;
	logic                f1_q, f2_q;
	logic [NIN-1:0]      in_ch_q, in_ch_d;
	logic [FBN-1:0]      fb_q;
	logic [CLW-1:0]      clr_q;
	logic [GCW-1:0]      ga_q;
	logic                v_s1, v_s2;
	logic [GW-1:0]       g_s1, g_s2;
	logic                a_ram_s2, a_val_s2, b_ram_s2, b_val_s2;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       slot_diff;
	logic                o_ram_q, o_val_q;
	logic [RES_W-1:0]    res_q;
	logic                err_q;
	logic                rsp_valid_q;
	logic [RES_W-1:0]    result_q;
	logic                error_q;

	logic                issue;
	logic                nand_s2;
	logic                o_bit;
	logic                slot_is_fb;
	logic [CW-1:0]       tgt_w, tgt_off, cur_s1;
	logic                gw_bad, mw_bad;
	src_cls_t            cls_a, cls_b, cls_o;

	logic                gs_we;
	logic [GW-1:0]       gs_waddr, gs_raddr;
	logic [SRC_W-1:0]    gs_wdata, gs_rd;
	logic                map_we;
	logic [SW-1:0]       map_waddr, map_raddr;
	logic [CH_IDX_W-1:0] map_wdata, map_rd;
	logic                ch_we;
	logic [GW-1:0]       ch_waddr, ch_ra_a, ch_ra_b;
	logic                ch_rd_a, ch_rd_b;

	nne_ram #(.WIDTH(SRC_W), .DEPTH(GATE_COUNT)) u_gate_ram (
		.clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata),
		.raddr(gs_raddr), .rdata(gs_rd)
	);

	nne_ram #(.WIDTH(CH_IDX_W), .DEPTH(NSLOTS)) u_map_ram (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rd)
	);

	nne_ram #(.WIDTH(1), .DEPTH(GATE_COUNT)) u_chan_a_ram (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(nand_s2),
		.raddr(ch_ra_a), .rdata(ch_rd_a)
	);

	nne_ram #(.WIDTH(1), .DEPTH(GATE_COUNT)) u_chan_b_ram (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(nand_s2),
		.raddr(ch_ra_b), .rdata(ch_rd_b)
	);

	// input channel vector: operand A, then operand B (both MSB first) or saved feedback in slot order
	always_comb begin
		int sh;
		in_ch_d = '0;
		for (int i = 0; i < DATA_BITS; i++) begin
			sh = DATA_BITS - 1 - i;
			in_ch_d[i] = (sh < OPER_W) ? operand_a[3'(sh)] : 1'b0;
			if (req_type_t'(req_type) == REQ_EVAL_FB) begin
				in_ch_d[DATA_BITS + i] = (i < FEEDBACK_OUTPUTS) ? fb_q[FW'(i)] : 1'b0;
			end else begin
				in_ch_d[DATA_BITS + i] = (sh < OPER_W) ? operand_b[3'(sh)] : 1'b0;
			end
		end
	end

	assign tgt_w   = CW'(tgt_q);
	assign tgt_off = tgt_w - CW'(NIN);
	assign gw_bad  = (tgt_w < CW'(NIN)) || (tgt_w >= CW'(NCH)) ||
		(f1_q && (CW'(s1_q) >= CW'(NCH))) || (f2_q && (CW'(s2_q) >= CW'(NCH)));
	assign mw_bad  = (tgt_w >= CW'(NSLOTS)) || (CW'(s1_q) >= CW'(NCH));

	assign cur_s1  = CW'(g_s1) + CW'(NIN);
	assign nand_s2 = ~((a_ram_s2 ? ch_rd_a : a_val_s2) & (b_ram_s2 ? ch_rd_b : b_val_s2));
	assign cls_a   = classify(gs_rd[SRC_W-1:CH_IDX_W], cur_s1, in_ch_q, v_s2, g_s2, nand_s2);
	assign cls_b   = classify(gs_rd[CH_IDX_W-1:0], cur_s1, in_ch_q, v_s2, g_s2, nand_s2);
	assign cls_o   = classify(map_rd, CW'(NCH), in_ch_q, 1'b0, '0, 1'b0);
	assign o_bit   = o_ram_q ? ch_rd_a : o_val_q;

	assign slot_diff  = slot_q - SW'(DIRECT_OUTPUTS);
	assign slot_is_fb = (FEEDBACK_OUTPUTS > 0) && (slot_q >= SW'(DIRECT_OUTPUTS));

	assign ch_we    = (state_q == ST_EVAL) && v_s2;
	assign ch_waddr = g_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		issue     = 1'b0;
		gs_we     = 1'b0;
		gs_waddr  = tgt_off[GW-1:0];
		gs_wdata  = '0;
		gs_raddr  = ga_q[GW-1:0];
		map_we    = 1'b0;
		map_waddr = tgt_q[SW-1:0];
		map_wdata = s1_q;
		map_raddr = slot_q;
		ch_ra_a   = cls_a.addr;
		ch_ra_b   = cls_b.addr;
		case (state_q)
			ST_CLEAR: begin
				gs_we     = clr_q < CLW'(GATE_COUNT);
				gs_waddr  = clr_q[GW-1:0];
				map_we    = clr_q < CLW'(NSLOTS);
				map_waddr = clr_q[SW-1:0];
				map_wdata = '0;
				if (clr_q == CLW'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (req_q)
					REQ_GATE_WR: begin
						gs_raddr = tgt_off[GW-1:0];
						state_d  = gw_bad ? ST_RESP : ST_GW_WR;
					end
					REQ_MAP_WR: begin
						map_we  = !mw_bad;
						state_d = ST_RESP;
					end
					default: begin
						state_d = ST_EVAL;
					end
				endcase
			end
			ST_GW_WR: begin
				gs_we    = 1'b1;
				gs_wdata = {f1_q ? s1_q : gs_rd[SRC_W-1:CH_IDX_W],
					f2_q ? s2_q : gs_rd[CH_IDX_W-1:0]};
				state_d  = ST_RESP;
			end
			ST_EVAL: begin
				issue = ga_q < GCW'(GATE_COUNT);
				if (!issue && !v_s1 && !v_s2) begin
					state_d = ST_OUT_RD;
				end
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_CH;
			end
			ST_OUT_CH: begin
				ch_ra_a = cls_o.addr;
				state_d = ST_OUT_COL;
			end
			ST_OUT_COL: begin
				state_d = (slot_q == SW'(NSLOTS - 1)) ? ST_RESP : ST_OUT_RD;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ga_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			slot_q      <= '0;
			fb_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == ST_DECODE) begin
				ga_q   <= '0;
				slot_q <= '0;
			end else begin
				if (issue) begin
					ga_q <= ga_q + GCW'(1);
				end
				if (state_q == ST_OUT_COL) begin
					slot_q <= slot_q + SW'(1);
				end
			end
			if (state_q == ST_OUT_COL && slot_is_fb) begin
				fb_q[slot_diff[FW-1:0]] <= o_bit;
			end
			if (state_q == ST_RESP && state_d == ST_IDLE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q   <= req_type_t'(req_type);
			tgt_q   <= target;
			s1_q    <= first_source;
			s2_q    <= second_source;
			f1_q    <= set_first;
			f2_q    <= set_second;
			in_ch_q <= in_ch_d;
		end
		g_s1     <= ga_q[GW-1:0];
		g_s2     <= g_s1;
		a_ram_s2 <= cls_a.use_ram;
		a_val_s2 <= cls_a.val;
		b_ram_s2 <= cls_b.use_ram;
		b_val_s2 <= cls_b.val;
		if (state_q == ST_OUT_CH) begin
			o_ram_q <= cls_o.use_ram;
			o_val_q <= cls_o.val;
		end
		if (state_q == ST_DECODE) begin
			res_q <= '0;
			err_q <= ((req_q == REQ_GATE_WR) && gw_bad) || ((req_q == REQ_MAP_WR) && mw_bad);
		end else if (state_q == ST_OUT_COL && !slot_is_fb) begin
			res_q <= {res_q[RES_W-2:0], o_bit};
		end
		if (state_q == ST_RESP && state_d == ST_IDLE) begin
			result_q <= res_q;
			error_q  <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;
	assign error     = error_q;

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result word raised outside the response state");

	a_gate_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2) |-> (g_s1 == g_s2 + GW'(1)))
		else $error("gate pipeline stages out of index order");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && error_q) |-> (result_q == '0))
		else $error("rejected write carries a nonzero result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DECODE))
		else $error("accepted word did not enter decode");

endmodule
